// ===== sv/scs_pkg.sv =====
package scs_pkg;

  // step count limit and the widths that follow from it
  localparam int unsigned MaxSteps = 32767;
  localparam int unsigned MagW     = $clog2(MaxSteps + 1);
  localparam int unsigned MulW     = MagW + 4;

  // configuration registers
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegHalfPeriod = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFireTicks  = 1'b1;
  localparam logic [CfgW-1:0] HalfPeriodReset = 16'd4;
  localparam logic [CfgW-1:0] FireTicksReset  = 16'd100;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // characters of interest
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChColon   = 8'h3a;
  localparam logic [7:0] ChFire    = 8'h66;
  localparam logic [7:0] ChPlus    = 8'h2b;
  localparam logic [7:0] ChMinus   = 8'h2d;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  // count parser phases
  typedef enum logic [1:0] {
    PhWs     = 2'd0,
    PhSign   = 2'd1,
    PhDigits = 2'd2,
    PhDone   = 2'd3
  } parse_phase_e;

  typedef struct packed {
    parse_phase_e    phase;
    logic            neg;
    logic [MagW-1:0] mag;
  } parse_t;

  // classified item handed from front to back
  typedef struct packed {
    logic       is_tick;
    logic       is_newline;
    logic       is_colon;
    logic       is_fire;
    logic       is_plus;
    logic       is_minus;
    logic       is_space;
    logic       is_digit;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic [CfgW-1:0] half_period;
    logic [CfgW-1:0] fire_ticks;
  } cfg_t;

  typedef struct packed {
    logic x_step;
    logic x_dir;
    logic x_en;
    logic y_step;
    logic y_dir;
    logic y_en;
    logic fire;
  } pins_t;

  typedef struct packed {
    pins_t pins;
    logic  busy;
    logic  dropped;
  } result_t;

endpackage

// ===== sv/scs_front.sv =====
module scs_front (
  input  logic          req_type_i,
  input  logic [7:0]    rx_byte_i,
  output scs_pkg::item_t item_o
);

  logic [7:0] digit_off;

  // byte classes used by the line parser
  assign digit_off = rx_byte_i - scs_pkg::ChZero;

  always_comb begin
    item_o.is_tick    = req_type_i;
    item_o.is_newline = (rx_byte_i == scs_pkg::ChNewline);
    item_o.is_colon   = (rx_byte_i == scs_pkg::ChColon);
    item_o.is_fire    = (rx_byte_i == scs_pkg::ChFire);
    item_o.is_plus    = (rx_byte_i == scs_pkg::ChPlus);
    item_o.is_minus   = (rx_byte_i == scs_pkg::ChMinus);
    item_o.is_space   = (rx_byte_i == scs_pkg::ChSpace) ||
                        ((rx_byte_i >= scs_pkg::ChTab) && (rx_byte_i <= scs_pkg::ChCr));
    item_o.is_digit   = (rx_byte_i >= scs_pkg::ChZero) && (rx_byte_i <= scs_pkg::ChNine);
    item_o.digit      = digit_off[3:0];
  end

endmodule

// ===== sv/scs_queue.sv =====
module scs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scs_pkg::item_t push_item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output scs_pkg::item_t pop_item_o
);

  scs_pkg::item_t                   mem_q [scs_pkg::QueueDepth];
  logic [scs_pkg::QueuePtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [scs_pkg::QueueCntW-1:0]    cnt_q;
  logic                             do_push, do_pop;

  assign ready_o    = (cnt_q != scs_pkg::QueueCntW'(scs_pkg::QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == scs_pkg::QueuePtrW'(scs_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == scs_pkg::QueuePtrW'(scs_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/scs_back.sv =====
module scs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scs_pkg::cfg_t    cfg_i,
  input  logic             item_valid_i,
  input  scs_pkg::item_t   item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output scs_pkg::result_t result_o
);

  typedef enum logic [2:0] {
    RunIdle = 3'd0,
    RunFire = 3'd1,
    RunXHi  = 3'd2,
    RunXLo  = 3'd3,
    RunYHi  = 3'd4,
    RunYLo  = 3'd5
  } run_e;

  run_e                         run_q, run_d;
  logic                         line_empty_q, line_empty_d;
  logic                         fire_line_q, fire_line_d;
  logic                         second_q, second_d;
  scs_pkg::parse_t              x_q, x_d, y_q, y_d;
  logic [scs_pkg::MagW-1:0]     pulses_q, pulses_d, pulses_dec;
  logic [scs_pkg::CfgW-1:0]     ticks_q, ticks_d, hp_load, fire_load;
  scs_pkg::pins_t               pins_q, pins_d;
  logic                         dropped;
  logic                         start_y;
  logic                         out_valid_q;
  scs_pkg::result_t             result_q;

  // one byte step of the count parser
  function automatic scs_pkg::parse_t feed(scs_pkg::parse_t p, scs_pkg::item_t it);
    scs_pkg::parse_t          r;
    logic [scs_pkg::MulW-1:0] prod;
    r    = p;
    prod = scs_pkg::MulW'({p.mag, 3'b000}) + scs_pkg::MulW'({p.mag, 1'b0}) +
           scs_pkg::MulW'(it.digit);
    if (p.phase == scs_pkg::PhWs && it.is_space) begin
      r = p;
    end else if (p.phase == scs_pkg::PhWs && it.is_plus) begin
      r.phase = scs_pkg::PhSign;
    end else if (p.phase == scs_pkg::PhWs && it.is_minus) begin
      r.neg   = 1'b1;
      r.phase = scs_pkg::PhSign;
    end else if (p.phase == scs_pkg::PhDone) begin
      r = p;
    end else if (it.is_digit) begin
      if (prod > scs_pkg::MulW'(scs_pkg::MaxSteps)) begin
        r.mag = scs_pkg::MagW'(scs_pkg::MaxSteps);
      end else begin
        r.mag = prod[scs_pkg::MagW-1:0];
      end
      r.phase = scs_pkg::PhDigits;
    end else begin
      r.phase = scs_pkg::PhDone;
    end
    return r;
  endfunction

  assign pop_o      = item_valid_i && (!out_valid_q || out_ready_i);
  assign hp_load    = (cfg_i.half_period == '0) ? scs_pkg::CfgW'(1) : cfg_i.half_period;
  assign fire_load  = (cfg_i.fire_ticks == '0) ? scs_pkg::CfgW'(1) : cfg_i.fire_ticks;
  assign pulses_dec = (pulses_q != '0) ? pulses_q - 1'b1 : pulses_q;

  // next state for the popped item
  always_comb begin
    run_d        = run_q;
    line_empty_d = line_empty_q;
    fire_line_d  = fire_line_q;
    second_d     = second_q;
    x_d          = x_q;
    y_d          = y_q;
    pulses_d     = pulses_q;
    ticks_d      = ticks_q;
    pins_d       = pins_q;
    dropped      = 1'b0;
    start_y      = 1'b0;

    if (item_i.is_tick) begin
      if (run_q != RunIdle) begin
        if (ticks_q > scs_pkg::CfgW'(1)) begin
          ticks_d = ticks_q - 1'b1;
        end else begin
          case (run_q)
            RunFire: begin
              pins_d.fire = 1'b0;
              run_d       = RunIdle;
            end
            RunXHi: begin
              pins_d.x_step = 1'b0;
              ticks_d       = hp_load;
              run_d         = RunXLo;
            end
            RunXLo: begin
              pulses_d = pulses_dec;
              if (pulses_dec != '0) begin
                pins_d.x_step = 1'b1;
                ticks_d       = hp_load;
                run_d         = RunXHi;
              end else begin
                pins_d.x_en = 1'b1;
                start_y     = 1'b1;
              end
            end
            RunYHi: begin
              pins_d.y_step = 1'b0;
              ticks_d       = hp_load;
              run_d         = RunYLo;
            end
            RunYLo: begin
              pulses_d = pulses_dec;
              if (pulses_dec != '0) begin
                pins_d.y_step = 1'b1;
                ticks_d       = hp_load;
                run_d         = RunYHi;
              end else begin
                pins_d.y_en = 1'b1;
                run_d       = RunIdle;
              end
            end
            default: run_d = RunIdle;
          endcase
        end
      end
    end else if (run_q != RunIdle) begin
      dropped = 1'b1;
    end else if (item_i.is_newline) begin
      // end of line: clear line state and launch the command
      line_empty_d = 1'b1;
      fire_line_d  = 1'b0;
      second_d     = 1'b0;
      x_d          = '{phase: scs_pkg::PhWs, neg: 1'b0, mag: '0};
      if (fire_line_q) begin
        pins_d.fire = 1'b1;
        ticks_d     = fire_load;
        run_d       = RunFire;
        y_d         = '{phase: scs_pkg::PhWs, neg: 1'b0, mag: '0};
      end else if (x_q.mag != '0) begin
        pins_d.x_dir  = !x_q.neg;
        pins_d.x_en   = 1'b0;
        pins_d.x_step = 1'b1;
        pulses_d      = x_q.mag;
        ticks_d       = hp_load;
        run_d         = RunXHi;
      end else begin
        start_y = 1'b1;
      end
    end else begin
      if (line_empty_q && item_i.is_fire) begin
        fire_line_d = 1'b1;
      end
      line_empty_d = 1'b0;
      if (item_i.is_colon) begin
        second_d = 1'b1;
      end else if (!second_q) begin
        x_d = feed(x_q, item_i);
      end else begin
        y_d = feed(y_q, item_i);
      end
    end

    // y move launch, from a finished x move or a line without x count
    if (start_y) begin
      y_d = '{phase: scs_pkg::PhWs, neg: 1'b0, mag: '0};
      if (y_q.mag == '0) begin
        run_d = RunIdle;
      end else begin
        pins_d.y_dir  = !y_q.neg;
        pins_d.y_en   = 1'b0;
        pins_d.y_step = 1'b1;
        pulses_d      = y_q.mag;
        ticks_d       = hp_load;
        run_d         = RunYHi;
      end
    end
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= RunIdle;
      line_empty_q <= 1'b1;
      fire_line_q  <= 1'b0;
      second_q     <= 1'b0;
      x_q          <= '{phase: scs_pkg::PhWs, neg: 1'b0, mag: '0};
      y_q          <= '{phase: scs_pkg::PhWs, neg: 1'b0, mag: '0};
      pulses_q     <= '0;
      ticks_q      <= '0;
      pins_q       <= '0;
      out_valid_q  <= 1'b0;
      result_q     <= '0;
    end else begin
      if (pop_o) begin
        run_q        <= run_d;
        line_empty_q <= line_empty_d;
        fire_line_q  <= fire_line_d;
        second_q     <= second_d;
        x_q          <= x_d;
        y_q          <= y_d;
        pulses_q     <= pulses_d;
        ticks_q      <= ticks_d;
        pins_q       <= pins_d;
        out_valid_q  <= 1'b1;
        result_q     <= '{pins: pins_d, busy: (run_d != RunIdle), dropped: dropped};
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

// ===== sv/serial_command_stepper_sequencer.sv =====
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------
// input    | in_valid_i/in_ready_o | req_type_i, rx_byte_i
// result   | out_valid_o/out_ready_i | x/y step, dir, enable, fire, busy, dropped
// config   | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// one item per cycle sustained while results are taken; the back state is registered when its item is popped
// an accepted item passes the queue entry, then the result register, before its result
// is offered and can be taken
// reset: pins low, parser and sequencer idle, half_period 4, fire_ticks 100
// a stalled result holds the back part; the two-entry queue takes at most two more items,
// then in_ready_o stays low until the result is taken
module serial_command_stepper_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         x_step_o,
  output logic                         x_dir_o,
  output logic                         x_enable_level_o,
  output logic                         y_step_o,
  output logic                         y_dir_o,
  output logic                         y_enable_level_o,
  output logic                         fire_out_o,
  output logic                         busy_res_o,
  output logic                         byte_dropped_o,
  input  logic                         cfg_we_i,
  input  logic [scs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [scs_pkg::CfgW-1:0]     cfg_data_i
);

  scs_pkg::item_t   front_item, queue_item;
  scs_pkg::cfg_t    cfg_q;
  scs_pkg::result_t result;
  logic             queue_valid, back_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period <= scs_pkg::HalfPeriodReset;
      cfg_q.fire_ticks  <= scs_pkg::FireTicksReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        scs_pkg::RegHalfPeriod: cfg_q.half_period <= cfg_data_i;
        scs_pkg::RegFireTicks:  cfg_q.fire_ticks  <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // byte classification
  scs_front u_front (
    .req_type_i (req_type_i),
    .rx_byte_i  (rx_byte_i),
    .item_o     (front_item)
  );

  // decoupling queue
  scs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .ready_o     (in_ready_o),
    .pop_i       (back_pop),
    .valid_o     (queue_valid),
    .pop_item_o  (queue_item)
  );

  // line parser and motion sequencer
  scs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .pop_o        (back_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign x_step_o         = result.pins.x_step;
  assign x_dir_o          = result.pins.x_dir;
  assign x_enable_level_o = result.pins.x_en;
  assign y_step_o         = result.pins.y_step;
  assign y_dir_o          = result.pins.y_dir;
  assign y_enable_level_o = result.pins.y_en;
  assign fire_out_o       = result.pins.fire;
  assign busy_res_o       = result.busy;
  assign byte_dropped_o   = result.dropped;

endmodule

// ===== tb/serial_command_stepper_sequencer_tb.sv =====
`timescale 1ns / 100ps

module serial_command_stepper_sequencer_tb;

  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned PhaseItems    = 180;
  localparam int unsigned MaxReports    = 200;
  localparam int unsigned NumPhases     = 6;

  // request kinds on the input channel
  localparam bit ReqByte = 1'b0;
  localparam bit ReqTick = 1'b1;

  // whitespace and terminator bytes not named in the package
  localparam logic [7:0] ChVTab     = 8'h0b;
  localparam logic [7:0] ChFormFeed = 8'h0c;
  localparam logic [7:0] ChNul      = 8'h00;

  typedef enum logic [2:0] {
    RunIdle,
    RunFire,
    RunXHigh,
    RunXLow,
    RunYHigh,
    RunYLow
  } run_phase_e;

  // tracks parser and sequencer state, holds the pin levels due per item
  class pin_scoreboard;
    logic [scs_pkg::CfgW-1:0] half_period;
    logic [scs_pkg::CfgW-1:0] fire_ticks;
    bit                       line_blank;
    bit                       fire_cmd;
    bit                       on_y_field;
    scs_pkg::parse_t          x_count;
    scs_pkg::parse_t          y_count;
    run_phase_e               seq_phase;
    int unsigned              steps_left;
    int unsigned              ticks_left;
    scs_pkg::pins_t           pins;
    scs_pkg::result_t         levels_due[$];
    int unsigned              errors;
    string                    field_name[9] = '{"byte_dropped", "busy_res", "fire_out",
                                                "y_enable_level", "y_dir", "y_step",
                                                "x_enable_level", "x_dir", "x_step"};

    function new();
      half_period = scs_pkg::HalfPeriodReset;
      fire_ticks  = scs_pkg::FireTicksReset;
      reset_line();
      reset_y();
      seq_phase  = RunIdle;
      steps_left = 0;
      ticks_left = 0;
      pins       = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [scs_pkg::CfgIdxW-1:0] idx,
                            logic [scs_pkg::CfgW-1:0] data);
      case (idx)
        scs_pkg::RegHalfPeriod: half_period = data;
        scs_pkg::RegFireTicks:  fire_ticks = data;
        default: ;
      endcase
    endfunction

    function bit busy();
      return seq_phase != RunIdle;
    endfunction

    function int unsigned pending();
      return levels_due.size();
    endfunction

    // a zero setting counts as one tick
    function int unsigned span_of(logic [scs_pkg::CfgW-1:0] v);
      return (v == '0) ? 1 : int'(v);
    endfunction

    // atol-like count parser, one byte at a time, saturating
    function scs_pkg::parse_t parse_char(scs_pkg::parse_t p, logic [7:0] c);
      bit          digit;
      bit          space;
      int unsigned v;
      digit = (c >= scs_pkg::ChZero) && (c <= scs_pkg::ChNine);
      space = (c == scs_pkg::ChSpace) || ((c >= scs_pkg::ChTab) && (c <= scs_pkg::ChCr));
      if (p.phase == scs_pkg::PhWs) begin
        if (space) return p;
        if (c == scs_pkg::ChPlus) begin
          p.phase = scs_pkg::PhSign;
          return p;
        end
        if (c == scs_pkg::ChMinus) begin
          p.neg   = 1'b1;
          p.phase = scs_pkg::PhSign;
          return p;
        end
      end
      if (p.phase == scs_pkg::PhDone) return p;
      if (digit) begin
        v = 32'(p.mag) * 10 + 32'(c - scs_pkg::ChZero);
        if (v > scs_pkg::MaxSteps) v = scs_pkg::MaxSteps;
        p.mag   = v[scs_pkg::MagW-1:0];
        p.phase = scs_pkg::PhDigits;
      end else begin
        p.phase = scs_pkg::PhDone;
      end
      return p;
    endfunction

    function void reset_line();
      line_blank = 1'b1;
      fire_cmd   = 1'b0;
      on_y_field = 1'b0;
      x_count    = '0;
    endfunction

    function void reset_y();
      y_count = '0;
    endfunction

    function bit begin_y();
      if (y_count.mag == '0) begin
        reset_y();
        return 1'b0;
      end
      pins.y_dir  = !y_count.neg;
      pins.y_en   = 1'b0;
      pins.y_step = 1'b1;
      steps_left  = y_count.mag;
      ticks_left  = span_of(half_period);
      seq_phase   = RunYHigh;
      reset_y();
      return 1'b1;
    endfunction

    // newline: fire, or start X, or go straight to Y
    function void run_line();
      if (fire_cmd) begin
        pins.fire  = 1'b1;
        ticks_left = span_of(fire_ticks);
        seq_phase  = RunFire;
        reset_line();
        reset_y();
        return;
      end
      if (x_count.mag != '0) begin
        pins.x_dir  = !x_count.neg;
        pins.x_en   = 1'b0;
        pins.x_step = 1'b1;
        steps_left  = x_count.mag;
        ticks_left  = span_of(half_period);
        seq_phase   = RunXHigh;
        reset_line();
        return;
      end
      reset_line();
      if (!begin_y()) seq_phase = RunIdle;
    endfunction

    // one millisecond tick of the pulse sequencer
    function void take_tick();
      if (seq_phase == RunIdle) return;
      if (ticks_left > 1) begin
        ticks_left--;
        return;
      end
      case (seq_phase)
        RunFire: begin
          pins.fire = 1'b0;
          seq_phase = RunIdle;
        end
        RunXHigh: begin
          pins.x_step = 1'b0;
          ticks_left  = span_of(half_period);
          seq_phase   = RunXLow;
        end
        RunXLow: begin
          if (steps_left > 0) steps_left--;
          if (steps_left > 0) begin
            pins.x_step = 1'b1;
            ticks_left  = span_of(half_period);
            seq_phase   = RunXHigh;
          end else begin
            pins.x_en = 1'b1;
            if (!begin_y()) seq_phase = RunIdle;
          end
        end
        RunYHigh: begin
          pins.y_step = 1'b0;
          ticks_left  = span_of(half_period);
          seq_phase   = RunYLow;
        end
        RunYLow: begin
          if (steps_left > 0) steps_left--;
          if (steps_left > 0) begin
            pins.y_step = 1'b1;
            ticks_left  = span_of(half_period);
            seq_phase   = RunYHigh;
          end else begin
            pins.y_en = 1'b1;
            seq_phase = RunIdle;
          end
        end
        default: seq_phase = RunIdle;
      endcase
    endfunction

    // accepted input item: update state and queue the levels it leaves
    function void accept_item(bit req, logic [7:0] c);
      scs_pkg::result_t want;
      bit               dropped;
      dropped = 1'b0;
      if (req == ReqTick) begin
        take_tick();
      end else if (seq_phase != RunIdle) begin
        dropped = 1'b1;
      end else if (c == scs_pkg::ChNewline) begin
        run_line();
      end else begin
        if (line_blank && c == scs_pkg::ChFire) fire_cmd = 1'b1;
        line_blank = 1'b0;
        if (c == scs_pkg::ChColon) on_y_field = 1'b1;
        else if (!on_y_field) x_count = parse_char(x_count, c);
        else y_count = parse_char(y_count, c);
      end
      want.pins    = pins;
      want.busy    = (seq_phase != RunIdle);
      want.dropped = dropped;
      levels_due.push_back(want);
    endfunction

    // accepted result: compare with the oldest levels due
    function void check_levels(scs_pkg::result_t got);
      scs_pkg::result_t want;
      logic [8:0]       w;
      logic [8:0]       g;
      if (levels_due.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: result with nothing due, expected none actual %b", $time, got);
        return;
      end
      want = levels_due.pop_front();
      w    = want;
      g    = got;
      for (int i = 0; i < 9; i++) begin
        if (g[i] !== w[i]) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: %s expected %0b actual %0b", $time, field_name[i], w[i], g[i]);
        end
      end
    endfunction
  endclass

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_valid   = 1'b0;
  logic                         in_ready;
  logic                         req_type   = ReqByte;
  logic [7:0]                   rx_byte    = '0;
  logic                         out_valid;
  logic                         out_ready  = 1'b0;
  logic                         x_step;
  logic                         x_dir;
  logic                         x_enable_level;
  logic                         y_step;
  logic                         y_dir;
  logic                         y_enable_level;
  logic                         fire_out;
  logic                         busy_res;
  logic                         byte_dropped;
  logic                         cfg_we     = 1'b0;
  logic [scs_pkg::CfgIdxW-1:0]  cfg_idx    = scs_pkg::RegHalfPeriod;
  logic [scs_pkg::CfgW-1:0]     cfg_data   = '0;

  pin_scoreboard       sb = new();
  scs_pkg::result_t    seen_levels;
  logic [7:0]          cmd_bytes[$];
  int unsigned         burst_left = 0;
  int unsigned         gap_max    = 4;
  int unsigned         items_sent = 0;
  int unsigned         idle_cycles = 0;
  logic                pressure_on = 1'b0;
  bit                  pressure_done = 1'b0;
  int unsigned         hold_left = 0;
  int unsigned         pattern_age = 0;
  logic [7:0]          ready_pattern = 8'hff;

  int unsigned phase_half[NumPhases] = '{1, 2, 0, 1, 3, 1};
  int unsigned phase_fire[NumPhases] = '{1, 3, 0, 7, 2, 1};
  int unsigned phase_gap[NumPhases]  = '{4, 2, 6, 0, 1, 3};

  serial_command_stepper_sequencer DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .req_type_i       (req_type),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .x_step_o         (x_step),
    .x_dir_o          (x_dir),
    .x_enable_level_o (x_enable_level),
    .y_step_o         (y_step),
    .y_dir_o          (y_dir),
    .y_enable_level_o (y_enable_level),
    .fire_out_o       (fire_out),
    .busy_res_o       (busy_res),
    .byte_dropped_o   (byte_dropped),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // both handshakes, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.accept_item(req_type, rx_byte);
      if (out_valid && out_ready) begin
        seen_levels.pins.x_step = x_step;
        seen_levels.pins.x_dir  = x_dir;
        seen_levels.pins.x_en   = x_enable_level;
        seen_levels.pins.y_step = y_step;
        seen_levels.pins.y_dir  = y_dir;
        seen_levels.pins.y_en   = y_enable_level;
        seen_levels.pins.fire   = fire_out;
        seen_levels.busy        = busy_res;
        seen_levels.dropped     = byte_dropped;
        sb.check_levels(seen_levels);
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: long hold-offs and a rotating stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (pressure_on && !pressure_done) begin
      out_ready     <= 1'b0;
      hold_left     <= HoldOffCycles;
      pressure_done <= 1'b1;
    end else if ($urandom_range(0, 2999) == 0) begin
      out_ready <= 1'b0;
      hold_left <= $urandom_range(20, 150);
    end else begin
      out_ready <= ready_pattern[pattern_age % 8];
      if (pattern_age == 31) begin
        pattern_age <= 0;
        case ($urandom_range(0, 3))
          0: ready_pattern <= 8'hff;
          1: ready_pattern <= 8'($urandom);
          2: ready_pattern <= 8'($urandom | $urandom);
          default: ready_pattern <= 8'($urandom & $urandom);
        endcase
      end else begin
        pattern_age <= pattern_age + 1;
      end
    end
  end

  // offer one item, with burst gaps, and wait until it is taken
  task automatic send_item(input bit req, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= req;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(ReqByte, s[i]);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(ReqTick, 8'($urandom_range(0, 255)));
  endtask

  // stop offering and wait for every due result
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // tick until the sequencer is back to idle, pipeline empty
  task automatic finish_motion();
    wait_quiet();
    while (sb.busy()) begin
      send_ticks(16);
      wait_quiet();
    end
  endtask

  task automatic write_reg(input logic [scs_pkg::CfgIdxW-1:0] idx,
                           input logic [scs_pkg::CfgW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == scs_pkg::ChNewline);
    return b;
  endfunction

  function automatic logic [7:0] space_byte();
    case ($urandom_range(0, 4))
      0: return scs_pkg::ChSpace;
      1: return scs_pkg::ChTab;
      2: return ChVTab;
      3: return ChFormFeed;
      default: return scs_pkg::ChCr;
    endcase
  endfunction

  // append one count field; returns the magnitude it was meant to carry
  function automatic int unsigned add_count();
    int unsigned mag;
    string       digits;
    repeat ($urandom_range(0, 2)) cmd_bytes.push_back(space_byte());
    case ($urandom_range(0, 3))
      0: cmd_bytes.push_back(scs_pkg::ChPlus);
      1: cmd_bytes.push_back(scs_pkg::ChMinus);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) return 0;
    mag = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
    if ($urandom_range(0, 7) == 0) cmd_bytes.push_back(scs_pkg::ChZero);
    digits = $sformatf("%0d", mag);
    foreach (digits[i]) cmd_bytes.push_back(digits[i]);
    if ($urandom_range(0, 3) == 0) cmd_bytes.push_back(junk_byte());
    return mag;
  endfunction

  // one command line, then roughly the ticks it needs, with stray bytes
  task automatic random_command();
    int unsigned x_mag;
    int unsigned y_mag;
    int unsigned need;
    int unsigned span;
    cmd_bytes.delete();
    x_mag = 0;
    y_mag = 0;
    span  = sb.span_of(sb.half_period);
    case ($urandom_range(0, 11))
      0: begin
        cmd_bytes.push_back(scs_pkg::ChFire);
        repeat ($urandom_range(0, 3)) cmd_bytes.push_back(junk_byte());
        cmd_bytes.push_back(scs_pkg::ChNewline);
        need = sb.span_of(sb.fire_ticks);
      end
      1: begin
        repeat ($urandom_range(1, 8)) cmd_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) != 0) cmd_bytes.push_back(scs_pkg::ChNewline);
        need = $urandom_range(0, 8);
      end
      default: begin
        x_mag = add_count();
        if ($urandom_range(0, 4) != 0) begin
          cmd_bytes.push_back(scs_pkg::ChColon);
          y_mag = add_count();
          if ($urandom_range(0, 7) == 0) cmd_bytes.push_back(scs_pkg::ChColon);
        end
        cmd_bytes.push_back(scs_pkg::ChNewline);
        need = 2 * span * (x_mag + y_mag);
      end
    endcase
    // now and then cut the run short or overshoot
    case ($urandom_range(0, 7))
      0: need = need / 2;
      1: need = need + $urandom_range(1, 6);
      default: ;
    endcase
    foreach (cmd_bytes[i]) send_item(ReqByte, cmd_bytes[i]);
    for (int i = 0; i < need; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(ReqByte, 8'($urandom_range(0, 255)));
      send_item(ReqTick, 8'($urandom_range(0, 255)));
    end
    items_sent += cmd_bytes.size() + need;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick while idle, then one negative X pulse at the reset period
    send_item(ReqTick, 8'hff);
    send_text("-1\n");
    send_ticks(8);
    finish_motion();
    write_reg(scs_pkg::RegHalfPeriod, 16'd1);
    write_reg(scs_pkg::RegFireTicks, 16'd2);

    // empty line, fire with a newline dropped, nul ending a zero X then Y only
    send_text("\n");
    send_text("f\n");
    send_item(ReqByte, scs_pkg::ChNewline);
    send_ticks(2);
    send_item(ReqByte, scs_pkg::ChZero);
    send_item(ReqByte, ChNul);
    send_text("2:-1\n");
    send_ticks(2);

    // random command lines over several settings
    for (int p = 0; p < NumPhases; p++) begin
      finish_motion();
      write_reg(scs_pkg::RegHalfPeriod, 16'(phase_half[p]));
      write_reg(scs_pkg::RegFireTicks, 16'(phase_fire[p]));
      gap_max = phase_gap[p];
      if (phase_gap[p] == 0) pressure_on <= 1'b1;
      items_sent = 0;
      while (items_sent < PhaseItems) random_command();
    end

    // oversized count with a zero period setting, then the largest settings mid-move
    finish_motion();
    write_reg(scs_pkg::RegHalfPeriod, 16'd0);
    gap_max = 1;
    send_text("-99999\n");
    send_ticks(60);
    send_text("1\n");
    send_ticks(4);
    wait_quiet();
    write_reg(scs_pkg::RegHalfPeriod, 16'hffff);
    write_reg(scs_pkg::RegFireTicks, 16'hffff);
    send_ticks(40);
    wait_quiet();

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
